>>> hw/rtl/mctp_pkg.sv
`timescale 1ns / 1ps
package mctp_pkg;

   localparam int TIMERS_DEFAULT = 8;

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_CREATE = 3'd1;
   localparam logic [2:0] MODE_CANCEL = 3'd2;
   localparam logic [2:0] MODE_MODIFY = 3'd3;
   localparam logic [2:0] MODE_QUERY  = 3'd4;

   localparam logic [1:0] KIND_ONE_SHOT = 2'd0;
   localparam logic [1:0] KIND_BURST    = 2'd1;
   localparam logic [1:0] KIND_PERIODIC = 2'd2;
   localparam logic [1:0] KIND_RESERVED = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [2:0]  timer_id;
      logic [31:0] delay;
      logic [1:0]  timer_kind;
      logic [31:0] shot_count;
      logic        notify;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [2:0] new_id;
      logic       running;
      logic [7:0] fired_mask;
      logic       any_active;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic tick_rd;
      logic tick_wb;
      logic scan;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] mode;
      logic       slot_busy;
   } stat_type;

endpackage

>>> hw/rtl/mctp_ctrl.sv
`timescale 1ns / 1ps
module mctp_ctrl #(
   parameter int TIMERS = mctp_pkg::TIMERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  mctp_pkg::stat_type            stat,
   output mctp_pkg::cmd_type             cmd,
   output logic [$clog2(TIMERS+1)-1:0]   sweep_cnt
);

   localparam int CNT_W = $clog2(TIMERS + 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EXEC   = 5'b00010,
      ST_TICK   = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_free;
   logic             at_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign sweep_cnt = cnt_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign at_end    = (cnt_ff == CNT_W'(TIMERS - 1));

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            cnt_in   = '0;
            if (stat.mode == mctp_pkg::MODE_TICK) begin
               state_in = ST_TICK;
            end else if (stat.mode == mctp_pkg::MODE_CREATE) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_TICK: begin
            // read slot cnt while writing back slot cnt-1
            cmd.tick_rd = (cnt_ff < CNT_W'(TIMERS));
            cmd.tick_wb = (cnt_ff != '0);
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TIMERS)) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            cnt_in   = cnt_ff + CNT_W'(1);
            if (!stat.slot_busy || at_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/mctp_datapath.sv
`timescale 1ns / 1ps
module mctp_datapath #(
   parameter int TIMERS = mctp_pkg::TIMERS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mctp_pkg::req_type             req_data,
   output mctp_pkg::rsp_type             rsp_data,
   input  mctp_pkg::cmd_type             cmd,
   input  logic [$clog2(TIMERS+1)-1:0]   sweep_cnt,
   output mctp_pkg::stat_type            stat
);

   localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam int CNT_W = $clog2(TIMERS + 1);

   mctp_pkg::req_type req_ff;
   mctp_pkg::rsp_type rsp_ff, rsp_in;

   logic [TIMERS-1:0] active_ff, active_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic [1:0]  kind_mem   [TIMERS];
   logic [31:0] period_mem [TIMERS];
   logic [31:0] rem_mem    [TIMERS];
   logic [31:0] shots_mem  [TIMERS];
   logic        notify_mem [TIMERS];

   logic [1:0]       rd_kind_ff;
   logic [31:0]      rd_period_ff;
   logic [31:0]      rd_rem_ff;
   logic [31:0]      rd_shots_ff;
   logic             rd_notify_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   logic       status_ff, status_in;
   logic [2:0] new_id_ff, new_id_in;
   logic       running_ff, running_in;
   logic [7:0] fired_ff, fired_in;

   logic [IDX_W-1:0] sweep_idx, id_idx, wr_idx;
   logic             id_ok, id_active;
   logic             rem_we, period_we, shots_we, meta_we;
   logic [31:0]      rem_wd, period_wd, shots_wd;
   logic [1:0]       kind_wd;
   logic [31:0]      rem_dec;
   logic             hit, reload;
   logic [2:0]       fired_pos;

   assign sweep_idx  = sweep_cnt[IDX_W-1:0];
   assign id_idx     = IDX_W'(req_ff.timer_id);
   assign id_ok      = (32'(req_ff.timer_id) < 32'(TIMERS));
   assign id_active  = id_ok && active_ff[id_idx];
   assign stat.mode      = req_ff.mode;
   assign stat.slot_busy = active_ff[sweep_idx];
   assign rsp_data   = rsp_ff;

   assign rem_dec   = (rd_rem_ff != 32'd0) ? rd_rem_ff - 32'd1 : 32'd0;
   assign hit       = (rem_dec == 32'd0);
   assign reload    = (rd_kind_ff == mctp_pkg::KIND_PERIODIC) ||
                      ((rd_kind_ff == mctp_pkg::KIND_BURST) && (rd_shots_ff > 32'd1));
   assign fired_pos = 3'(rd_idx_ff);
   assign kind_wd   = (req_ff.timer_kind == mctp_pkg::KIND_RESERVED) ? mctp_pkg::KIND_ONE_SHOT
                                                                     : req_ff.timer_kind;

   always_comb begin
      active_in  = active_ff;
      count_in   = count_ff;
      status_in  = status_ff;
      new_id_in  = new_id_ff;
      running_in = running_ff;
      fired_in   = fired_ff;
      rem_we     = 1'b0;
      period_we  = 1'b0;
      shots_we   = 1'b0;
      meta_we    = 1'b0;
      rem_wd     = req_ff.delay;
      period_wd  = req_ff.delay;
      shots_wd   = (req_ff.timer_kind == mctp_pkg::KIND_BURST) ? req_ff.shot_count : 32'd0;
      wr_idx     = sweep_idx;
      rsp_in     = rsp_ff;

      if (cmd.exec) begin
         status_in  = 1'b0;
         new_id_in  = 3'd0;
         running_in = 1'b0;
         fired_in   = 8'd0;
         wr_idx     = id_idx;
         case (req_ff.mode)
            mctp_pkg::MODE_TICK: begin
            end
            mctp_pkg::MODE_CREATE: begin
               // cleared by the scan once a free slot turns up
               status_in = 1'b1;
            end
            mctp_pkg::MODE_CANCEL: begin
               if (id_active) begin
                  active_in[id_idx] = 1'b0;
                  count_in          = count_ff - CNT_W'(1);
               end else begin
                  status_in = 1'b1;
               end
            end
            mctp_pkg::MODE_MODIFY: begin
               if (id_active) begin
                  rem_we    = 1'b1;
                  period_we = 1'b1;
               end else begin
                  status_in = 1'b1;
               end
            end
            mctp_pkg::MODE_QUERY: begin
               status_in  = !id_ok;
               running_in = id_active;
            end
            default: begin
               status_in = 1'b1;
            end
         endcase
      end

      if (cmd.scan && !active_ff[sweep_idx]) begin
         active_in[sweep_idx] = 1'b1;
         count_in             = count_ff + CNT_W'(1);
         status_in            = 1'b0;
         new_id_in            = 3'(sweep_idx);
         rem_we               = 1'b1;
         period_we            = 1'b1;
         shots_we             = 1'b1;
         meta_we              = 1'b1;
      end

      if (cmd.tick_wb && active_ff[rd_idx_ff]) begin
         wr_idx = rd_idx_ff;
         rem_we = 1'b1;
         rem_wd = rem_dec;
         if (hit) begin
            if (rd_notify_ff && (32'(rd_idx_ff) < 32'd8)) begin
               fired_in[fired_pos] = 1'b1;
            end
            if (reload) begin
               rem_wd = rd_period_ff;
               if (rd_kind_ff == mctp_pkg::KIND_BURST) begin
                  shots_we = 1'b1;
                  shots_wd = rd_shots_ff - 32'd1;
               end
            end else begin
               active_in[rd_idx_ff] = 1'b0;
               count_in             = count_ff - CNT_W'(1);
            end
         end
      end

      if (cmd.load_rsp) begin
         rsp_in.status     = status_ff;
         rsp_in.new_id     = new_id_ff;
         rsp_in.running    = running_ff;
         rsp_in.fired_mask = fired_ff;
         rsp_in.any_active = (count_ff != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (rem_we) begin
         rem_mem[wr_idx] <= rem_wd;
      end
      if (period_we) begin
         period_mem[wr_idx] <= period_wd;
      end
      if (shots_we) begin
         shots_mem[wr_idx] <= shots_wd;
      end
      if (meta_we) begin
         kind_mem[wr_idx]   <= kind_wd;
         notify_mem[wr_idx] <= req_ff.notify;
      end
      if (cmd.tick_rd) begin
         rd_kind_ff   <= kind_mem[sweep_idx];
         rd_period_ff <= period_mem[sweep_idx];
         rd_rem_ff    <= rem_mem[sweep_idx];
         rd_shots_ff  <= shots_mem[sweep_idx];
         rd_notify_ff <= notify_mem[sweep_idx];
         rd_idx_ff    <= sweep_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      status_ff  <= status_in;
      new_id_ff  <= new_id_in;
      running_ff <= running_in;
      fired_ff   <= fired_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/multi_channel_timer_pool_top.sv
`timescale 1ns / 1ps
// Pool of TIMERS countdown timers driven by one request at a time.
// Request channel (req_valid / req_stall / req_data) carries a command:
// tick, create, cancel, modify or query. Response channel (rsp_valid /
// rsp_stall / rsp_data) returns one result per request: status, new_id,
// running, fired_mask and any_active.
// Tick walks the slot memory one slot per cycle (registered read, then
// write back); create scans the active bits one slot per cycle for the
// lowest free one; cancel, modify, query and unknown modes go straight
// from execution to the response. A new request is taken once the
// previous one has reached the response register.
// req_stall is high while a request is in progress. If the receiver holds
// rsp_stall, the finished result waits in its register and the next
// request may be accepted; its own result waits until the slot frees.
// Synchronous reset clears all active bits and the active count; slot
// contents are written by create before they are used.
module multi_channel_timer_pool_top #(
   parameter int TIMERS = mctp_pkg::TIMERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mctp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mctp_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(TIMERS + 1);

   mctp_pkg::cmd_type  cmd;
   mctp_pkg::stat_type stat;
   logic [CNT_W-1:0]   sweep_cnt;

   mctp_ctrl #(
      .TIMERS (TIMERS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd),
      .sweep_cnt (sweep_cnt)
   );

   mctp_datapath #(
      .TIMERS (TIMERS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sweep_cnt (sweep_cnt),
      .stat      (stat)
   );

endmodule

>>> tb/sv/multi_channel_timer_pool_top_tb.sv
`timescale 1ns / 1ps
module multi_channel_timer_pool_top_tb;

   localparam int TIMERS = mctp_pkg::TIMERS_DEFAULT;
   localparam logic [2:0] MODE_ILLEGAL_FIRST = mctp_pkg::MODE_QUERY + 3'd1;
   localparam logic [2:0] MODE_ILLEGAL_LAST  = 3'd7;
   localparam int ITEMS_PER_PHASE = 175;
   localparam int IDLE_LIMIT      = 5000;

   class timer_pool_scoreboard;
      bit                slot_on[TIMERS];
      logic [1:0]        slot_mode_kind[TIMERS];
      logic [31:0]       slot_period[TIMERS];
      logic [31:0]       slot_remaining[TIMERS];
      logic [31:0]       slot_shots[TIMERS];
      bit                slot_reports[TIMERS];
      mctp_pkg::rsp_type pending_results[$];
      int                mismatches;

      function new();
         mismatches = 0;
         foreach (slot_on[i]) slot_on[i] = 1'b0;
      endfunction

      function mctp_pkg::rsp_type predict_result(mctp_pkg::req_type r);
         mctp_pkg::rsp_type res;
         bit                id_ok;
         res   = '0;
         id_ok = (int'(r.timer_id) < TIMERS);
         case (r.mode)
            mctp_pkg::MODE_TICK: begin
               for (int i = 0; i < TIMERS; i++) begin
                  if (slot_on[i]) begin
                     if (slot_remaining[i] != 0) slot_remaining[i]--;
                     if (slot_remaining[i] == 0) begin
                        if (slot_reports[i]) res.fired_mask[i] = 1'b1;
                        if (slot_mode_kind[i] == mctp_pkg::KIND_PERIODIC) begin
                           slot_remaining[i] = slot_period[i];
                        end else if (slot_mode_kind[i] == mctp_pkg::KIND_BURST &&
                                     slot_shots[i] > 1) begin
                           slot_shots[i]--;
                           slot_remaining[i] = slot_period[i];
                        end else begin
                           slot_on[i] = 1'b0;
                        end
                     end
                  end
               end
            end
            mctp_pkg::MODE_CREATE: begin
               res.status = 1'b1;
               for (int i = 0; i < TIMERS; i++) begin
                  if (res.status && !slot_on[i]) begin
                     slot_on[i]        = 1'b1;
                     slot_mode_kind[i] = (r.timer_kind == mctp_pkg::KIND_RESERVED)
                                         ? mctp_pkg::KIND_ONE_SHOT : r.timer_kind;
                     slot_period[i]    = r.delay;
                     slot_remaining[i] = r.delay;
                     slot_shots[i]     = (r.timer_kind == mctp_pkg::KIND_BURST)
                                         ? r.shot_count : '0;
                     slot_reports[i]   = r.notify;
                     res.status        = 1'b0;
                     res.new_id        = 3'(i);
                  end
               end
            end
            mctp_pkg::MODE_CANCEL: begin
               if (id_ok && slot_on[r.timer_id]) slot_on[r.timer_id] = 1'b0;
               else res.status = 1'b1;
            end
            mctp_pkg::MODE_MODIFY: begin
               if (id_ok && slot_on[r.timer_id]) begin
                  slot_period[r.timer_id]    = r.delay;
                  slot_remaining[r.timer_id] = r.delay;
               end else begin
                  res.status = 1'b1;
               end
            end
            mctp_pkg::MODE_QUERY: begin
               if (id_ok) res.running = slot_on[r.timer_id];
               else res.status = 1'b1;
            end
            default: res.status = 1'b1;
         endcase
         foreach (slot_on[i]) if (slot_on[i]) res.any_active = 1'b1;
         return res;
      endfunction

      function string fmt_rsp(mctp_pkg::rsp_type v);
         return $sformatf("status %0d new_id %0d running %0d fired %02h active %0d",
                          v.status, v.new_id, v.running, v.fired_mask, v.any_active);
      endfunction

      function void note_request(mctp_pkg::req_type r);
         pending_results.push_back(predict_result(r));
      endfunction

      function void check_result(mctp_pkg::rsp_type got);
         mctp_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: %s", fmt_rsp(got));
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.new_id !== want.new_id ||
             got.running !== want.running || got.fired_mask !== want.fired_mask ||
             got.any_active !== want.any_active) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %s, got %s", fmt_rsp(want), fmt_rsp(got));
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   mctp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mctp_pkg::rsp_type rsp_data;

   timer_pool_scoreboard timer_sb;
   int send_idle_pct;
   int recv_stall_pct;
   int idle_cycles = 0;

   multi_channel_timer_pool_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // sample at the edge: all signals still hold their pre-edge values here
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            timer_sb.note_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            timer_sb.check_result(rsp_data);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_channel_timer_pool_top_tb failed");
            $finish;
         end
      end
   end

   function automatic mctp_pkg::req_type make_request(logic [2:0] mode, logic [2:0] id,
                                                      logic [31:0] delay, logic [1:0] kind,
                                                      logic [31:0] reps, logic notify);
      mctp_pkg::req_type r;
      r.mode       = mode;
      r.timer_id   = id;
      r.delay      = delay;
      r.timer_kind = kind;
      r.shot_count = reps;
      r.notify     = notify;
      return r;
   endfunction

   function automatic mctp_pkg::req_type random_request();
      mctp_pkg::req_type r;
      int unsigned       pick;
      pick = $urandom_range(99);
      if (pick < 35)      r.mode = mctp_pkg::MODE_TICK;
      else if (pick < 60) r.mode = mctp_pkg::MODE_CREATE;
      else if (pick < 72) r.mode = mctp_pkg::MODE_CANCEL;
      else if (pick < 82) r.mode = mctp_pkg::MODE_MODIFY;
      else if (pick < 94) r.mode = mctp_pkg::MODE_QUERY;
      else r.mode = 3'($urandom_range(MODE_ILLEGAL_LAST, MODE_ILLEGAL_FIRST));
      r.timer_id = 3'($urandom);
      // mostly short delays so timers expire often; a few long ones fill the pool
      pick = $urandom_range(99);
      if (pick < 88)      r.delay = $urandom_range(6);
      else if (pick < 96) r.delay = $urandom;
      else                r.delay = '1;
      r.timer_kind = 2'($urandom);
      r.shot_count = ($urandom_range(99) < 75) ? $urandom_range(4) : $urandom;
      r.notify = 1'($urandom);
      return r;
   endfunction

   task automatic send_request(input mctp_pkg::req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off new requests until every outstanding response is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (timer_sb.pending_results.size() != 0);
   endtask

   task automatic run_directed();
      send_request(make_request(mctp_pkg::MODE_TICK, 3'd0, '0,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b1));
      send_request(make_request(mctp_pkg::MODE_QUERY, 3'd0, '0,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b0));
      send_request(make_request(mctp_pkg::MODE_CANCEL, 3'd7, '0,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b0));
      send_request(make_request(mctp_pkg::MODE_MODIFY, 3'd3, 32'd5,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b0));
      send_request(make_request(mctp_pkg::MODE_CREATE, 3'd0, '0,
                                mctp_pkg::KIND_ONE_SHOT, '1, 1'b1));
      send_request(make_request(mctp_pkg::MODE_CREATE, 3'd0, 32'd1,
                                mctp_pkg::KIND_BURST, 32'd2, 1'b1));
      send_request(make_request(mctp_pkg::MODE_CREATE, 3'd0, 32'd2,
                                mctp_pkg::KIND_PERIODIC, '1, 1'b0));
      send_request(make_request(mctp_pkg::MODE_CREATE, 3'd0, 32'd1,
                                mctp_pkg::KIND_RESERVED, 32'd9, 1'b1));
      send_request(make_request(mctp_pkg::MODE_CREATE, 3'd0, '1,
                                mctp_pkg::KIND_BURST, '0, 1'b1));
      send_request(make_request(mctp_pkg::MODE_CREATE, 3'd0, '0,
                                mctp_pkg::KIND_BURST, 32'd1, 1'b1));
      send_request(make_request(mctp_pkg::MODE_QUERY, 3'd1, '0,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b0));
      send_request(make_request(mctp_pkg::MODE_MODIFY, 3'd2, 32'd1,
                                mctp_pkg::KIND_BURST, '1, 1'b1));
      repeat (3) send_request(make_request(mctp_pkg::MODE_TICK, 3'd0, '1,
                                           mctp_pkg::KIND_RESERVED, '1, 1'b0));
      send_request(make_request(MODE_ILLEGAL_FIRST, 3'd2, '0,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b0));
      send_request(make_request(MODE_ILLEGAL_LAST, 3'd2, '0,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b0));
      // fill the pool with long timers until create reports it full
      repeat (7) send_request(make_request(mctp_pkg::MODE_CREATE, 3'd0, '1,
                                           mctp_pkg::KIND_PERIODIC, '0, 1'b1));
      send_request(make_request(mctp_pkg::MODE_CANCEL, 3'd2, '0,
                                mctp_pkg::KIND_ONE_SHOT, '0, 1'b0));
   endtask

   initial begin
      timer_sb = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 45 : (phase == 3) ? 27 : 0;
         recv_stall_pct = (phase == 2) ? 45 : (phase == 3) ? 27 : 0;
         repeat (ITEMS_PER_PHASE) send_request(random_request());
         drain();
      end

      recv_stall_pct = 0;
      repeat (TIMERS + 6) @(posedge clock);
      if (timer_sb.mismatches == 0 && timer_sb.pending_results.size() == 0) begin
         $display("multi_channel_timer_pool_top_tb passed");
      end else begin
         $display("multi_channel_timer_pool_top_tb failed");
      end
      $finish;
   end

endmodule
